FILE: hdl/clsr_pkg.sv
package clsr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WARM_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(WARM_STEPS);

    localparam int WORD_W = 31;
    localparam int MUL_W  = 16;
    localparam int PROD_W = WORD_W + MUL_W;
    localparam int FOLD_W = 8;

    localparam logic [31:0]       MOD_ONE    = 32'd2147483563;
    localparam logic [31:0]       MOD_TWO    = 32'd2147483399;
    localparam logic [MUL_W-1:0]  MUL_ONE    = 16'd40014;
    localparam logic [MUL_W-1:0]  MUL_TWO    = 16'd40692;
    localparam logic [WORD_W-1:0] TOP_VALUE  = WORD_W'(MOD_ONE - 32'd1);
    localparam logic [WORD_W-1:0] GEN1_RESET = WORD_W'(1);
    localparam logic [WORD_W-1:0] GEN2_RESET = WORD_W'(123456789);

    // 2^31 mod m for folding the product high part back in
    localparam logic [FOLD_W-1:0] FOLD_ONE = FOLD_W'(32'h8000_0000 - MOD_ONE);
    localparam logic [FOLD_W-1:0] FOLD_TWO = FOLD_W'(32'h8000_0000 - MOD_TWO);

    // slot index = word / SLOT_DIV by reciprocal estimate plus one correction
    localparam longint TOP_L        = 64'd2147483562;
    localparam longint SLOT_DIV_L   = 64'd1 + TOP_L / TABLE_DEPTH;
    localparam longint SLOT_RECIP_L = 64'd2147483648 / SLOT_DIV_L;
    localparam int     RECIP_W      = $clog2(SLOT_RECIP_L + 1);
    localparam int     IPROD_W      = WORD_W + RECIP_W;

    localparam logic [31:0]        SLOT_DIV   = 32'(SLOT_DIV_L);
    localparam logic [RECIP_W-1:0] SLOT_RECIP = RECIP_W'(SLOT_RECIP_L);

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_WARM_MUL = 8'b0000_0010,
        ST_WARM_RED = 8'b0000_0100,
        ST_G1_MUL   = 8'b0000_1000,
        ST_G1_RED   = 8'b0001_0000,
        ST_G2_MUL   = 8'b0010_0000,
        ST_G2_RED   = 8'b0100_0000,
        ST_MIX      = 8'b1000_0000
    } state_t;

endpackage

FILE: hdl/clsr_req_if.sv
interface clsr_req_if
    import clsr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [WORD_W-1:0] seed_value;

    modport source (output valid, output opcode, output seed_value, input ready);
    modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

FILE: hdl/clsr_rsp_if.sv
interface clsr_rsp_if
    import clsr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

FILE: hdl/combined_lcg_shuffle_rng.sv
// combined two-generator multiplicative rng with a shuffle table
//
// req channel: one word per request, opcode draw or reseed-then-draw, with
// seed_value used on reseed only (0 acts as 1, larger than the top value
// saturates). rsp channel: one word per request, random_value in
// 1..2147483562; the uniform fraction is that value over 2147483563.
// both channels use valid/ready and a word moves when both are high.
// a draw runs generator one multiply and reduce, generator two multiply and
// reduce, and mix, which writes the result for rsp. a reseed first runs 40
// warm-up steps of generator one, which also fill the 32-entry shuffle
// table. every step goes through one shared multiplier (multiply cycle)
// and one shared modular fold (reduce cycle). req.ready is high only
// between requests. the result sits in an output register; a stalled
// receiver lets the next request be taken and computed, and only its
// final write waits. after reset the generators hold 1 and 123456789 and
// the table reads as all zeros, so a draw without a reseed is allowed.
module combined_lcg_shuffle_rng
    import clsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    clsr_req_if.sink    req,
    clsr_rsp_if.source  rsp
);

    state_t state_reg, state_next;

    logic [WORD_W-1:0]      gen1_reg, gen1_next;
    logic [WORD_W-1:0]      gen2_reg, gen2_next;
    logic [WORD_W-1:0]      prev_reg, prev_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [RECIP_W-1:0]     qest_reg;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic                   out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]      out_data_reg, out_data_next;
    logic [TABLE_DEPTH-1:0] tvalid_reg;

    logic [WORD_W-1:0] shuf_mem [TABLE_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    logic              accept;
    logic              mix_go;
    logic [WORD_W-1:0] seed_sat;

    logic [WORD_W-1:0] mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [FOLD_W-1:0] fold_k;
    logic [31:0]       fold_m;
    logic [31:0]       red_sum;
    logic [31:0]       red_val;
    logic [WORD_W-1:0] red_word;

    logic [IPROD_W-1:0] idx_prod;
    logic [31:0]        idx_rem;
    logic [RECIP_W:0]   q_fix;

    logic [WORD_W-1:0] old_word;
    logic [31:0]       diff;
    logic [31:0]       mixed;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    assign req.ready        = (state_reg == ST_IDLE);
    assign accept           = req.valid && req.ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.random_value = out_data_reg;
    assign mix_go           = (state_reg == ST_MIX) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        if (req.seed_value == '0)
        begin
            seed_sat = WORD_W'(1);
        end
        else if (req.seed_value > TOP_VALUE)
        begin
            seed_sat = TOP_VALUE;
        end
        else
        begin
            seed_sat = req.seed_value;
        end
    end

    // shared multiplier and modular fold
    assign mul_a   = (state_reg == ST_G2_MUL) ? gen2_reg : gen1_reg;
    assign mul_b   = (state_reg == ST_G2_MUL) ? MUL_TWO : MUL_ONE;
    assign fold_k  = (state_reg == ST_G2_RED) ? FOLD_TWO : FOLD_ONE;
    assign fold_m  = (state_reg == ST_G2_RED) ? MOD_TWO : MOD_ONE;
    assign red_sum = 32'(prod_reg[PROD_W-1:WORD_W]) * 32'(fold_k)
                   + 32'(prod_reg[WORD_W-1:0]);
    assign red_val = (red_sum >= fold_m) ? red_sum - fold_m : red_sum;
    assign red_word = red_val[WORD_W-1:0];

    // slot index from previous output
    assign idx_prod = IPROD_W'(prev_reg) * IPROD_W'(SLOT_RECIP);
    assign idx_rem  = 32'(prev_reg) - 32'(qest_reg) * SLOT_DIV;
    assign q_fix    = (idx_rem >= SLOT_DIV) ? (RECIP_W + 1)'(qest_reg) + 1'b1
                                            : (RECIP_W + 1)'(qest_reg);

    always_comb
    begin
        if (32'(q_fix) > 32'(TABLE_DEPTH - 1))
        begin
            slot_next = IDX_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            slot_next = IDX_W'(q_fix);
        end
    end

    // combine old slot with generator two
    assign old_word = rd_valid_reg ? rd_data_reg : '0;
    assign diff     = 32'(old_word) - 32'(gen2_reg);
    assign mixed    = (diff[31] || diff == '0) ? diff + 32'(TOP_VALUE) : diff;

    always_comb
    begin
        state_next     = state_reg;
        gen1_next      = gen1_reg;
        gen2_next      = gen2_reg;
        prev_next      = prev_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_reg;
        wr_data        = gen1_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == OP_RESEED)
                    begin
                        gen1_next  = seed_sat;
                        gen2_next  = seed_sat;
                        cnt_next   = CNT_W'(WARM_STEPS - 1);
                        state_next = ST_WARM_MUL;
                    end
                    else
                    begin
                        state_next = ST_G1_MUL;
                    end
                end
            end
            ST_WARM_MUL:
            begin
                state_next = ST_WARM_RED;
            end
            ST_WARM_RED:
            begin
                gen1_next = red_word;
                if (32'(cnt_reg) < 32'(TABLE_DEPTH))
                begin
                    wr_en   = 1'b1;
                    wr_addr = cnt_reg[IDX_W-1:0];
                    wr_data = red_word;
                end
                if (cnt_reg == '0)
                begin
                    prev_next  = red_word;
                    state_next = ST_G1_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_WARM_MUL;
                end
            end
            ST_G1_MUL:
            begin
                state_next = ST_G1_RED;
            end
            ST_G1_RED:
            begin
                gen1_next  = red_word;
                state_next = ST_G2_MUL;
            end
            ST_G2_MUL:
            begin
                state_next = ST_G2_RED;
            end
            ST_G2_RED:
            begin
                gen2_next  = red_word;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (mix_go)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = slot_reg;
                    wr_data        = gen1_reg;
                    prev_next      = mixed[WORD_W-1:0];
                    out_data_next  = mixed[WORD_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen1_reg      <= GEN1_RESET;
            gen2_reg      <= GEN2_RESET;
            prev_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            tvalid_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            gen1_reg      <= gen1_next;
            gen2_reg      <= gen2_next;
            prev_reg      <= prev_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                tvalid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (state_reg == ST_WARM_MUL || state_reg == ST_G1_MUL || state_reg == ST_G2_MUL)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (state_reg == ST_G1_MUL)
        begin
            qest_reg <= idx_prod[IPROD_W-1:WORD_W];
        end
        if (state_reg == ST_G1_RED)
        begin
            slot_reg <= slot_next;
        end
    end

    // shuffle table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            shuf_mem[wr_addr] <= wr_data;
        end
        if (state_reg == ST_G2_MUL)
        begin
            rd_data_reg  <= shuf_mem[slot_reg];
            rd_valid_reg <= tvalid_reg[slot_reg];
        end
    end

`ifndef SYNTHESIS
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.random_value != '0) && (rsp.random_value <= TOP_VALUE))
        else $error("result word out of range");

    a_gen1_range: assert property (@(posedge clk) disable iff (!rst_n)
        (gen1_reg != '0) && (32'(gen1_reg) < MOD_ONE))
        else $error("generator one out of range");

    a_gen2_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX) |-> (32'(gen2_reg) < MOD_TWO))
        else $error("generator two not reduced before mix");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_G2_MUL) |-> (32'(slot_reg) < 32'(TABLE_DEPTH)))
        else $error("slot index beyond table");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while busy");
`endif

endmodule
